FILE: src/utrbf_pkg.sv
// Shared types, codes and constants for the UART transmit ring buffer feeder.
package utrbf_pkg;

  localparam int BUF_DEPTH_DEF = 1024;
  localparam int BUF_LEN_RESET = 1024;

  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 8;
  localparam int MLEN_W  = 10;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 11;
  localparam int STAT_W  = 2;

  localparam logic [DATA_W-1:0] MARKER_BYTE = 8'h0B;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROP    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_POLL,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic              first;
    logic [MLEN_W-1:0] mlen;
    logic              dma_done;
    logic [IDX_W-1:0]  ridx;
  } cmd_t;

endpackage

FILE: src/utrbf_ram.sv
// Generic single-port RAM with registered read data.
module utrbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/utrbf_front.sv
// Front end: takes items, decodes the function code and queues commands.
module utrbf_front import utrbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              first_i,
  input  logic [MLEN_W-1:0] msg_len_i,
  input  logic              dma_done_i,
  input  logic [IDX_W-1:0]  read_index_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;
  op_e        op_dec;

  always_comb begin
    case (func_i)
      FUNC_WRITE: op_dec = OP_WRITE;
      FUNC_POLL:  op_dec = OP_POLL;
      FUNC_READ:  op_dec = OP_READ;
      default:    op_dec = OP_NOP;
    endcase
  end

  always_comb begin
    cmd_in.op       = op_dec;
    cmd_in.data     = data_byte_i;
    cmd_in.first    = first_i;
    cmd_in.mlen     = msg_len_i;
    cmd_in.dma_done = dma_done_i;
    cmd_in.ridx     = read_index_i;
  end

  assign busy_o      = (count_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: src/utrbf_back.sv
// Back end: ring pointers, message state, DMA chunking and result registers.
module utrbf_back import utrbf_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic                         cmd_valid_i,
  input  cmd_t                         cmd_i,
  output logic                         cmd_pop_o,
  output logic                         ram_we_o,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_addr_o,
  output logic [DATA_W-1:0]            ram_wdata_o,
  input  logic [DATA_W-1:0]            ram_rdata_i,
  output logic                         done_o,
  output logic [STAT_W-1:0]            status_o,
  output logic                         dma_start_o,
  output logic [IDX_W-1:0]             dma_index_o,
  output logic [IDX_W-1:0]             dma_length_o,
  output logic [DATA_W-1:0]            read_data_o,
  output logic                         overflow_pending_o
);

  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int RING_MAX  = (BUF_DEPTH < CFG_MAX) ? BUF_DEPTH : CFG_MAX;
  localparam int PW        = $clog2(RING_MAX);
  localparam int LW        = $clog2(RING_MAX + 1);
  localparam int LW1       = LW + 1;
  localparam int RESET_LEN = (BUF_LEN_RESET > RING_MAX) ? RING_MAX : BUF_LEN_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_FREE,
    ST_EXEC,
    ST_ISSUE,
    ST_READ,
    ST_RDOUT
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [LW-1:0]     ring_len_q, ring_len_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     ss_q, ss_d;
  logic [PW-1:0]     se_q, se_d;
  logic [PW-1:0]     free_q, free_d;
  logic              ovf_q, ovf_d;
  logic              open_q, open_d;
  logic              acc_q, acc_d;
  logic [MLEN_W-1:0] left_q, left_d;
  logic              done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              dstart_q, dstart_d;
  logic [IDX_W-1:0]  didx_q, didx_d;
  logic [IDX_W-1:0]  dlen_q, dlen_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic              ovfo_q, ovfo_d;

  logic [LW-1:0]     wp_plus;
  logic [PW-1:0]     wp_inc;
  logic [LW1-1:0]    fs_sum;
  logic [LW1-1:0]    fs_red;
  logic              fits;
  logic              rd_in_range;
  logic [LW-1:0]     cfg_len;

  // next write position with wrap at the ring length
  assign wp_plus = LW'(wp_q) + LW'(1);
  assign wp_inc  = (wp_plus == ring_len_q) ? '0 : PW'(wp_plus);

  // free space = (ss - wp - 1) mod n, sum stays below 2n
  assign fs_sum = LW1'(ss_q) + LW1'(ring_len_q) - LW1'(wp_q) - LW1'(1);
  assign fs_red = (fs_sum >= LW1'(ring_len_q)) ? (fs_sum - LW1'(ring_len_q)) : fs_sum;

  assign fits        = !ovf_q && (32'(cmd_q.mlen) <= 32'(free_q));
  assign rd_in_range = (32'(cmd_i.ridx) < BUF_DEPTH);

  always_comb begin
    if (cfg_wdata_i < CFG_W'(2)) begin
      cfg_len = LW'(2);
    end else if (32'(cfg_wdata_i) > RING_MAX) begin
      cfg_len = LW'(RING_MAX);
    end else begin
      cfg_len = LW'(cfg_wdata_i);
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    ring_len_d = ring_len_q;
    wp_d       = wp_q;
    ss_d       = ss_q;
    se_d       = se_q;
    free_d     = free_q;
    ovf_d      = ovf_q;
    open_d     = open_q;
    acc_d      = acc_q;
    left_d     = left_q;
    done_d     = 1'b0;
    status_d   = STAT_OK;
    dstart_d   = 1'b0;
    didx_d     = '0;
    dlen_d     = '0;
    rdata_d    = '0;
    ovfo_d     = ovf_q;
    cmd_pop_o  = 1'b0;
    ram_we_o   = 1'b0;
    ram_wdata_o = cmd_q.data;
    ram_addr_o = (state_q == ST_READ) ? AW'(cmd_q.ridx) : AW'(wp_q);

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            OP_WRITE: state_d = ST_FREE;
            OP_POLL: begin
              if (open_q) begin
                done_d   = 1'b1;
                status_d = STAT_REFUSED;
              end else begin
                state_d = ST_RETIRE;
              end
            end
            OP_READ: begin
              if (rd_in_range) begin
                state_d = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_RETIRE: begin
        if ((se_q != ss_q) && cmd_q.dma_done) begin
          ss_d = se_q;
        end
        state_d = ST_FREE;
      end
      ST_FREE: begin
        free_d  = PW'(fs_red);
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q.op == OP_WRITE) begin
          if (cmd_q.first) begin
            open_d = 1'b0;
            acc_d  = 1'b0;
            left_d = '0;
            if (cmd_q.mlen == '0) begin
              status_d = STAT_DROP;
            end else begin
              if (!ovf_q && !fits) begin
                ovf_d = 1'b1;
              end
              acc_d  = fits;
              left_d = cmd_q.mlen - MLEN_W'(1);
              open_d = (cmd_q.mlen != MLEN_W'(1));
              if (fits) begin
                ram_we_o = 1'b1;
                wp_d     = wp_inc;
              end else begin
                status_d = STAT_DROP;
              end
            end
          end else if (open_q) begin
            if (acc_q) begin
              ram_we_o = 1'b1;
              wp_d     = wp_inc;
            end else begin
              status_d = STAT_DROP;
            end
            left_d = left_q - MLEN_W'(1);
            if (left_q == MLEN_W'(1)) begin
              open_d = 1'b0;
              acc_d  = 1'b0;
            end
          end else begin
            status_d = STAT_DROP;
          end
          ovfo_d  = ovf_d;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // poll: queue the overflow marker if a slot is free
          if (ovf_q && (free_q != '0)) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = MARKER_BYTE;
            wp_d        = wp_inc;
            ovf_d       = 1'b0;
          end
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (se_q == ss_q) begin
          if (ss_q < wp_q) begin
            dstart_d = 1'b1;
            didx_d   = IDX_W'(ss_q);
            dlen_d   = IDX_W'(wp_q - ss_q);
            se_d     = wp_q;
          end else if (ss_q > wp_q) begin
            dstart_d = 1'b1;
            didx_d   = IDX_W'(ss_q);
            dlen_d   = IDX_W'(ring_len_q - LW'(ss_q));
            se_d     = '0;
          end
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_RDOUT;
      ST_RDOUT: begin
        rdata_d = ram_rdata_i;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      ring_len_d = cfg_len;
      wp_d       = '0;
      ss_d       = '0;
      se_d       = '0;
      ovf_d      = 1'b0;
      open_d     = 1'b0;
      acc_d      = 1'b0;
      left_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= '0;
      ring_len_q <= LW'(RESET_LEN);
      wp_q       <= '0;
      ss_q       <= '0;
      se_q       <= '0;
      free_q     <= '0;
      ovf_q      <= 1'b0;
      open_q     <= 1'b0;
      acc_q      <= 1'b0;
      left_q     <= '0;
      done_q     <= 1'b0;
      status_q   <= STAT_OK;
      dstart_q   <= 1'b0;
      didx_q     <= '0;
      dlen_q     <= '0;
      rdata_q    <= '0;
      ovfo_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      ring_len_q <= ring_len_d;
      wp_q       <= wp_d;
      ss_q       <= ss_d;
      se_q       <= se_d;
      free_q     <= free_d;
      ovf_q      <= ovf_d;
      open_q     <= open_d;
      acc_q      <= acc_d;
      left_q     <= left_d;
      done_q     <= done_d;
      status_q   <= status_d;
      dstart_q   <= dstart_d;
      didx_q     <= didx_d;
      dlen_q     <= dlen_d;
      rdata_q    <= rdata_d;
      ovfo_q     <= ovfo_d;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign dma_start_o        = dstart_q;
  assign dma_index_o        = didx_q;
  assign dma_length_o       = dlen_q;
  assign read_data_o        = rdata_q;
  assign overflow_pending_o = ovfo_q;

`ifndef SYNTHESIS
  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < 32'(ring_len_q)) else $error("write pointer beyond ring length");

  a_ss_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ss_q) < 32'(ring_len_q)) else $error("send start beyond ring length");

  a_open_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != '0)) else $error("message open with no bytes left");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_IDLE || state_q == ST_EXEC ||
                     state_q == ST_ISSUE || state_q == ST_RDOUT))
    else $error("result strobe from a non-emitting state");

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart_q |-> (done_q && (status_q == STAT_OK)))
    else $error("DMA start without an ok result");
`endif

endmodule

FILE: src/uart_tx_ring_buffer_feeder.sv
// Top level of the UART transmit ring buffer feeder.
//
// Usage notes:
// - Items enter on start_i while busy_o is low: func_i selects write message
//   byte, poll tick or read buffer byte; the other fields ride along.
// - Every item produces exactly one result, shown for one cycle with done_o.
//   The receiver cannot stall; results must be taken when done_o is high.
// - A two-entry command queue sits between the decoder and the executing
//   sequencer, so an item can be taken while an earlier one is still at work.
// - The back-end sequencer works on one item at a time: a byte write takes
//   the free-space step and the write step; a poll may retire a sent chunk,
//   then takes the free-space step, the marker write and the chunk issue; an
//   in-range read waits on the registered read port of the byte store. A
//   refused poll, an unused code or an out-of-range read is answered at idle.
// - cfg_we_i/cfg_wdata_i write the ring length (clamped to 2..BUF_DEPTH) and
//   empty the ring; write it only while no item is in flight.
// - Reset empties the ring and sets the length to 1024 (or BUF_DEPTH if
//   smaller); the byte store is not cleared and holds garbage until written.
module uart_tx_ring_buffer_feeder import utrbf_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [DATA_W-1:0] data_byte_i,
  input  logic              first_i,
  input  logic [MLEN_W-1:0] msg_len_i,
  input  logic              dma_done_i,
  input  logic [IDX_W-1:0]  read_index_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic              dma_start_o,
  output logic [IDX_W-1:0]  dma_index_o,
  output logic [IDX_W-1:0]  dma_length_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic              overflow_pending_o
);

  localparam int AW = $clog2(BUF_DEPTH);

  cmd_t              cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // decode and queue
  utrbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .first_i      (first_i),
    .msg_len_i    (msg_len_i),
    .dma_done_i   (dma_done_i),
    .read_index_i (read_index_i),
    .busy_o       (busy_o),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // ring state and DMA chunking
  utrbf_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_valid_i        (cmd_valid),
    .cmd_i              (cmd),
    .cmd_pop_o          (cmd_pop),
    .ram_we_o           (ram_we),
    .ram_addr_o         (ram_addr),
    .ram_wdata_o        (ram_wdata),
    .ram_rdata_i        (ram_rdata),
    .done_o             (done_o),
    .status_o           (status_o),
    .dma_start_o        (dma_start_o),
    .dma_index_o        (dma_index_o),
    .dma_length_o       (dma_length_o),
    .read_data_o        (read_data_o),
    .overflow_pending_o (overflow_pending_o)
  );

  // byte store
  utrbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
